>>> src/pccs_pkg.sv
// ============================================================================
// pccs_pkg
// Shared types and constants for the particle cell counting sort block:
// field widths, mode codes and the controller/datapath command and status.
// ============================================================================
package pccs_pkg;

    // Default capacities.
    localparam int DEF_MAX_PARTICLES = 1024;
    localparam int DEF_MAX_CELLS     = 4096;

    // Field widths of the input and result words.
    localparam int MODE_W   = 2;
    localparam int CELL_W   = 12;
    localparam int SLOT_W   = 10;
    localparam int PNUM_W   = 10;
    localparam int START_W  = 11;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 13;

    // Reset value of the cells-in-use register.
    localparam logic [CFG_W-1:0] CELLS_RESET = 13'd4096;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_SLOT = 2'd1,
        MODE_CELL = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_en;  // input words may be taken
        logic clr_en;     // clear one histogram entry
        logic scan_init;  // reset scan sum and scatter index
        logic scan_en;    // issue one scan read
        logic scat_en;    // issue one scatter read
        logic set_done;   // the sort is complete
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic load_last;   // the load marked last was taken
        logic cnt_last;    // cell counter is at the final cell
        logic scat_last;   // scatter index is at the final particle
        logic scat_empty;  // no particles were accepted
        logic scat_busy;   // scatter pipeline still holds work
    } t_sts;

endpackage

>>> src/pccs_if.sv
// ============================================================================
// pccs interfaces
// Valid/ready channels of the block: input words, result words and the
// configuration write channel.
// ============================================================================

// Input word channel.
interface pccs_item_if import pccs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [CELL_W-1:0]   cell_index;
    logic [SLOT_W-1:0]   slot;
    logic                last_particle;

    modport source (output valid, mode, cell_index, slot, last_particle, input ready);
    modport sink   (input valid, mode, cell_index, slot, last_particle, output ready);
endinterface

// Result word channel.
interface pccs_result_if import pccs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PNUM_W-1:0]   particle_number;
    logic [START_W-1:0]  cell_start;
    logic [COUNT_W-1:0]  cell_count;
    logic                answer_valid;
    logic                error_flag;

    modport source (output valid, particle_number, cell_start, cell_count, answer_valid,
                    error_flag, input ready);
    modport sink   (input valid, particle_number, cell_start, cell_count, answer_valid,
                    error_flag, output ready);
endinterface

// Configuration write channel for the cells-in-use register.
interface pccs_cfg_if import pccs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> src/pccs_ctrl.sv
// ============================================================================
// pccs_ctrl
// Sequencer of the sort: histogram clear after reset, idle load/query phase,
// prefix scan over all cells and scatter over the loaded particles.
// ============================================================================
module pccs_ctrl import pccs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_FLUSH    = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_SCAN_END = 7'b0010000,
        ST_SCAT     = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.accept_en = 1'b1;
                if (i_sts.load_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // The final histogram update lands during this cycle.
                o_cmd.scan_init = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = i_sts.scat_empty ? ST_FINISH : ST_SCAT;
            end
            ST_SCAT: begin
                o_cmd.scat_en = 1'b1;
                if (i_sts.scat_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_sts.scat_busy) begin
                    o_cmd.set_done = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/pccs_dp.sv
// ============================================================================
// pccs_dp
// Datapath of the sort: histogram, cursor, cell and sorted-list memories,
// the load update pipeline, the prefix scan, the scatter pipeline and the
// query result register.
// ============================================================================
module pccs_dp import pccs_pkg::*; #(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int MAX_CELLS     = DEF_MAX_CELLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pccs_item_if.sink     i_item,
    pccs_result_if.source o_res,
    pccs_cfg_if.sink      i_cfg,
    input  t_cmd          i_cmd,
    output t_sts          o_sts
);

    localparam int PAW = $clog2(MAX_PARTICLES);
    localparam int PCW = $clog2(MAX_PARTICLES + 1);
    localparam int CAW = $clog2(MAX_CELLS);

    // Memories.
    logic [PCW-1:0]   hist_mem  [MAX_CELLS];
    logic [PCW-1:0]   cur_mem   [MAX_CELLS];
    logic [2*PCW-1:0] qry_mem   [MAX_CELLS];
    logic [CAW-1:0]   pcell_mem [MAX_PARTICLES];
    logic [PAW-1:0]   sort_mem  [MAX_PARTICLES];

    // Control registers.
    logic [CFG_W-1:0] r_cells;
    logic [PCW-1:0]   r_loaded;
    logic             r_done;
    logic             r_err;
    logic [CAW-1:0]   r_cnt;
    logic [PCW-1:0]   r_run;
    logic [PAW-1:0]   r_pi;
    logic             r_ld_v;
    logic             r_fw_v;
    logic             r_sc_v;
    logic             r_s1_v;
    logic             r_s2_v;
    logic             r_cfw_v;
    logic             r_res_v;

    // Payload registers.
    logic [PCW-1:0]   r_hist_rd;
    logic [CAW-1:0]   r_ld_cell;
    logic [CAW-1:0]   r_fw_cell;
    logic [PCW-1:0]   r_fw_data;
    logic [CAW-1:0]   r_sc_addr;
    logic [CAW-1:0]   r_pc_rd;
    logic [PAW-1:0]   r_s1_i;
    logic [PAW-1:0]   r_s2_i;
    logic [CAW-1:0]   r_s2_cell;
    logic [PCW-1:0]   r_cur_rd;
    logic [CAW-1:0]   r_cfw_cell;
    logic [PCW-1:0]   r_cfw_data;
    logic [PAW-1:0]   r_q_pn;
    logic [2*PCW-1:0] r_q_se;
    logic             r_res_is_slot;
    logic             r_res_ok;
    logic             r_res_err;

    // Combinational signals.
    logic             w_acc;
    logic             w_load;
    logic             w_query;
    logic             w_is_slot;
    logic [PCW-1:0]   w_eff_loaded;
    logic             w_full;
    logic [31:0]      w_active;
    logic             w_cell_ok;
    logic             w_good;
    logic [CAW-1:0]   w_cell_addr;
    logic [PCW-1:0]   w_ld_base;
    logic [PCW-1:0]   w_ld_sum;
    logic             w_cnt_last;
    logic             w_pi_last;
    logic [PCW-1:0]   w_pos;
    logic [PCW-1:0]   w_pos_nx;
    logic             w_query_ok;

    // Handshakes. Configuration is always taken.
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = i_cmd.accept_en && (!r_res_v || o_res.ready);
    assign w_acc        = i_item.valid && i_item.ready;
    assign w_load       = w_acc && (i_item.mode == MODE_LOAD);
    assign w_is_slot    = (i_item.mode == MODE_SLOT);
    assign w_query      = w_acc && (w_is_slot || (i_item.mode == MODE_CELL));

    // Load checks: capacity and cell range.
    assign w_eff_loaded = r_done ? '0 : r_loaded;
    assign w_full       = (w_eff_loaded >= PCW'(MAX_PARTICLES));
    assign w_active     = (32'(r_cells) > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : 32'(r_cells);
    assign w_cell_ok    = (32'(i_item.cell_index) < w_active);
    assign w_good       = w_load && !w_full && w_cell_ok;
    assign w_cell_addr  = CAW'(i_item.cell_index);

    // Histogram increment, forwarding the write that lands with the read.
    assign w_ld_base = (r_fw_v && (r_fw_cell == r_ld_cell)) ? r_fw_data : r_hist_rd;
    assign w_ld_sum  = PCW'(w_ld_base + PCW'(1));

    // Scatter cursor, forwarding the write that lands with the read.
    assign w_pos    = (r_cfw_v && (r_cfw_cell == r_s2_cell)) ? r_cfw_data : r_cur_rd;
    assign w_pos_nx = PCW'(w_pos + PCW'(1));

    assign w_cnt_last = (r_cnt == CAW'(MAX_CELLS - 1));
    assign w_pi_last  = ((PCW'(r_pi) + PCW'(1)) == r_loaded);

    // Query validity.
    assign w_query_ok = r_done && (w_is_slot ? (PCW'(i_item.slot) < r_loaded
                                                && 32'(i_item.slot) < 32'(MAX_PARTICLES))
                                             : w_cell_ok);

    // Status to the controller.
    assign o_sts.load_last  = w_load && i_item.last_particle;
    assign o_sts.cnt_last   = w_cnt_last;
    assign o_sts.scat_last  = w_pi_last;
    assign o_sts.scat_empty = (r_loaded == '0);
    assign o_sts.scat_busy  = r_s1_v || r_s2_v;

    // Histogram memory: load update, reset clear and clear behind the scan.
    always_ff @(posedge i_clk) begin
        if (r_ld_v) begin
            hist_mem[r_ld_cell] <= w_ld_sum;
        end else if (i_cmd.clr_en) begin
            hist_mem[r_cnt] <= '0;
        end else if (r_sc_v) begin
            hist_mem[r_sc_addr] <= '0;
        end
        if (w_good) begin
            r_hist_rd <= hist_mem[w_cell_addr];
        end else if (i_cmd.scan_en) begin
            r_hist_rd <= hist_mem[r_cnt];
        end
    end

    // Cursor memory: start offsets from the scan, advanced by the scatter.
    always_ff @(posedge i_clk) begin
        if (r_sc_v) begin
            cur_mem[r_sc_addr] <= r_run;
        end else if (r_s2_v) begin
            cur_mem[r_s2_cell] <= w_pos_nx;
        end
        if (r_s1_v) begin
            r_cur_rd <= cur_mem[r_pc_rd];
        end
    end

    // Cell query memory: start in the upper half, count in the lower half.
    always_ff @(posedge i_clk) begin
        if (r_sc_v) begin
            qry_mem[r_sc_addr] <= {r_run, r_hist_rd};
        end
        if (w_query) begin
            r_q_se <= qry_mem[w_cell_addr];
        end
    end

    // Cell of each loaded particle.
    always_ff @(posedge i_clk) begin
        if (w_good) begin
            pcell_mem[w_eff_loaded[PAW-1:0]] <= w_cell_addr;
        end
        if (i_cmd.scat_en) begin
            r_pc_rd <= pcell_mem[r_pi];
        end
    end

    // Sorted particle list.
    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            sort_mem[w_pos[PAW-1:0]] <= r_s2_i;
        end
        if (w_query) begin
            r_q_pn <= sort_mem[PAW'(i_item.slot)];
        end
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells  <= CELLS_RESET;
            r_loaded <= '0;
            r_done   <= 1'b0;
            r_err    <= 1'b0;
            r_cnt    <= '0;
            r_run    <= '0;
            r_pi     <= '0;
            r_ld_v   <= 1'b0;
            r_fw_v   <= 1'b0;
            r_sc_v   <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_cfw_v  <= 1'b0;
            r_res_v  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cells <= i_cfg.data;
            end

            // A load starts a new batch after a completed sort.
            if (w_load) begin
                r_loaded <= PCW'(w_eff_loaded + PCW'(w_good));
                r_done   <= 1'b0;
                if (!w_good) begin
                    r_err <= 1'b1;
                end
            end else if (i_cmd.set_done) begin
                r_done <= 1'b1;
            end

            // Cell counter shared by the reset clear and the scan.
            if (i_cmd.clr_en || i_cmd.scan_en) begin
                r_cnt <= w_cnt_last ? '0 : CAW'(r_cnt + CAW'(1));
            end

            // Running exclusive sum of the histogram.
            if (i_cmd.scan_init) begin
                r_run <= '0;
            end else if (r_sc_v) begin
                r_run <= PCW'(r_run + r_hist_rd);
            end

            // Scatter particle index.
            if (i_cmd.scan_init) begin
                r_pi <= '0;
            end else if (i_cmd.scat_en) begin
                r_pi <= PAW'(r_pi + PAW'(1));
            end

            r_ld_v  <= w_good;
            r_fw_v  <= r_ld_v;
            r_sc_v  <= i_cmd.scan_en;
            r_s1_v  <= i_cmd.scat_en;
            r_s2_v  <= r_s1_v;
            r_cfw_v <= r_s2_v;

            // Result register: filled by a query, emptied when taken.
            if (w_query) begin
                r_res_v <= 1'b1;
            end else if (o_res.ready) begin
                r_res_v <= 1'b0;
            end
        end
    end

    // Pipeline payloads.
    always_ff @(posedge i_clk) begin
        r_ld_cell  <= w_cell_addr;
        r_fw_cell  <= r_ld_cell;
        r_fw_data  <= w_ld_sum;
        r_sc_addr  <= r_cnt;
        r_s1_i     <= r_pi;
        r_s2_i     <= r_s1_i;
        r_s2_cell  <= r_pc_rd;
        r_cfw_cell <= r_s2_cell;
        r_cfw_data <= w_pos_nx;
        if (w_query) begin
            r_res_is_slot <= w_is_slot;
            r_res_ok      <= w_query_ok;
            r_res_err     <= r_err;
        end
    end

    // Result word; unused fields read as zero.
    assign o_res.valid           = r_res_v;
    assign o_res.answer_valid    = r_res_ok;
    assign o_res.error_flag      = r_res_err;
    assign o_res.particle_number = (r_res_ok && r_res_is_slot) ? PNUM_W'(r_q_pn) : '0;
    assign o_res.cell_start      = (r_res_ok && !r_res_is_slot)
                                   ? START_W'(r_q_se[2*PCW-1:PCW]) : '0;
    assign o_res.cell_count      = (r_res_ok && !r_res_is_slot)
                                   ? COUNT_W'(r_q_se[PCW-1:0]) : '0;

endmodule

>>> src/particle_cell_counting_sort.sv
// ============================================================================
// particle_cell_counting_sort
// Stable counting sort of particles by grid cell, with slot and cell queries.
// ============================================================================
// Loads and queries are taken one word per cycle while no earlier result is
// held by the sink; a query's result appears in the cycle after it is taken.
// The load marked last stalls the input while the prefix scan walks every
// cell of the histogram memory once, one cell per cycle, and the scatter
// then walks the loaded particles one per cycle through a three-stage
// read/update pipeline on the cursor memory. After reset the block clears
// every entry of the histogram memory before it takes its first word;
// configuration writes are taken at any time.
module particle_cell_counting_sort import pccs_pkg::*; #(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
    parameter int MAX_CELLS     = DEF_MAX_CELLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pccs_item_if.sink     i_item,
    pccs_result_if.source o_res,
    pccs_cfg_if.sink      i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    pccs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Memories and pipelines.
    pccs_dp #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_CELLS     (MAX_CELLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule
